[sv/rrst_pkg.sv]
// Shared constants, codes and control types for the range rank/select table.
package rrst_pkg;

    localparam int MAX_RANGES = 1024;
    localparam int POS_BITS   = 32;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam logic [WORD_W-1:0] POS_MASK = (POS_BITS >= WORD_W) ? '1 :
        WORD_W'((64'(1) << POS_BITS) - 64'(1));

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_POS2RK = 2'd2,
        REQ_RK2POS = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BAD_RANGE = 2'd3
    } stat_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_START,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic start;
        logic step;
        logic push;
    } dp_cmd_t;

    typedef struct packed {
        req_code_t req_in;
        logic      empty;
        logic      hit;
        logic      more;
        logic      out_free;
    } dp_stat_t;

endpackage

[sv/rrst_req_if.sv]
// Request channel: valid/ready handshake carrying one request word.
interface rrst_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [31:0] query_value;

    modport source (output valid, output req_type, output range_start,
                    output range_end, output query_value, input ready);
    modport sink (input valid, input req_type, input range_start,
                  input range_end, input query_value, output ready);
endinterface

[sv/rrst_rsp_if.sv]
// Response channel: valid/ready handshake carrying one result word.
interface rrst_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] answer;
    logic [1:0]  status;

    modport source (output valid, output answer, output status, input ready);
    modport sink (input valid, input answer, input status, output ready);
endinterface

[sv/rrst_ctrl.sv]
// Controller state machine sequencing table updates and binary searches.
module rrst_ctrl
    import rrst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (stat.req_in == REQ_CLEAR || stat.req_in == REQ_APPEND)
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = stat.empty ? ST_DONE : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (stat.hit || !stat.more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && (stat.hit || !stat.more)) |=> state_reg == ST_DONE)
        else $error("search did not finish after its last probe");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after delivering a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.exec, cmd.start, cmd.step, cmd.push}))
        else $error("more than one datapath command in one cycle");

endmodule

[sv/rrst_dp.sv]
// Datapath: range table memory, counters, search bounds and result register.
module rrst_dp
    import rrst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        in_req_type,
    input  logic [WORD_W-1:0] in_range_start,
    input  logic [WORD_W-1:0] in_range_end,
    input  logic [WORD_W-1:0] in_query_value,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_answer,
    output logic [1:0]        out_status
);

    typedef struct packed {
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] high;
        logic [WORD_W-1:0] base;
    } entry_t;

    entry_t mem [MAX_RANGES];
    entry_t rd_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;

    req_code_t         req_reg;
    logic [WORD_W-1:0] start_reg;
    logic [WORD_W-1:0] end_reg;
    logic [WORD_W-1:0] query_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] rank_reg, rank_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  mid_reg, mid_next;
    logic [WORD_W-1:0] res_ans_reg, res_ans_next;
    stat_code_t        res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_ans_reg, out_ans_next;
    stat_code_t        out_st_reg, out_st_next;

    logic [WORD_W-1:0] pos_q;
    logic [WORD_W-1:0] rank_diff;
    logic [WORD_W-1:0] span_len;
    logic              go_left;
    logic              go_right;
    logic [WORD_W-1:0] hit_ans;
    logic [CNT_W-1:0]  lo_cand;
    logic [CNT_W-1:0]  hi_cand;

    function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] hi_ex);
        logic [CNT_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi_ex} - {{CNT_W{1'b0}}, 1'b1};
        return sum[IDX_W:1];
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{low: start_reg, high: end_reg, base: rank_reg};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_code_t'(in_req_type);
            start_reg <= in_range_start & POS_MASK;
            end_reg   <= in_range_end & POS_MASK;
            query_reg <= in_query_value;
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        res_ans_reg <= res_ans_next;
        res_st_reg  <= res_st_next;
        out_ans_reg <= out_ans_next;
        out_st_reg  <= out_st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        pos_q     = query_reg & POS_MASK;
        rank_diff = query_reg - rd_reg.base;
        span_len  = rd_reg.high - rd_reg.low;
        if (req_reg == REQ_POS2RK)
        begin
            go_left  = pos_q < rd_reg.low;
            go_right = !go_left && (pos_q >= rd_reg.high);
            hit_ans  = rd_reg.base + (pos_q - rd_reg.low);
        end
        else
        begin
            go_left  = query_reg < rd_reg.base;
            go_right = !go_left && (rank_diff >= span_len);
            hit_ans  = rd_reg.low + rank_diff;
        end
        lo_cand = go_right ? ({1'b0, mid_reg} + CNT_W'(1)) : lo_reg;
        hi_cand = go_left ? {1'b0, mid_reg} : hi_reg;
    end

    always_comb
    begin
        count_next     = count_reg;
        rank_next      = rank_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        res_ans_next   = res_ans_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_ans_next   = out_ans_reg;
        out_st_next    = out_st_reg;
        rd_en          = 1'b0;
        rd_addr        = mid_of(lo_reg, hi_reg);
        wr_en          = 1'b0;

        if (cmd.exec)
        begin
            res_ans_next = '0;
            res_st_next  = STAT_OK;
            if (req_reg == REQ_CLEAR)
            begin
                count_next = '0;
                rank_next  = '0;
            end
            else if (end_reg < start_reg)
            begin
                res_st_next = STAT_BAD_RANGE;
            end
            else if (count_reg == CNT_W'(MAX_RANGES))
            begin
                res_st_next = STAT_FULL;
            end
            else
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                rank_next  = rank_reg + (end_reg - start_reg);
            end
        end

        if (cmd.start)
        begin
            lo_next = '0;
            hi_next = count_reg;
            rd_addr = mid_of('0, count_reg);
            if (count_reg == '0)
            begin
                res_ans_next = '0;
                res_st_next  = STAT_NOT_FOUND;
            end
            else
            begin
                rd_en    = 1'b1;
                mid_next = rd_addr;
            end
        end

        if (cmd.step)
        begin
            if (!go_left && !go_right)
            begin
                res_ans_next = hit_ans;
                res_st_next  = STAT_OK;
            end
            else if (lo_cand < hi_cand)
            begin
                lo_next  = lo_cand;
                hi_next  = hi_cand;
                rd_addr  = mid_of(lo_cand, hi_cand);
                rd_en    = 1'b1;
                mid_next = rd_addr;
            end
            else
            begin
                res_ans_next = '0;
                res_st_next  = STAT_NOT_FOUND;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            out_ans_next   = res_ans_reg;
            out_st_next    = res_st_reg;
        end
    end

    assign stat.req_in   = req_code_t'(in_req_type);
    assign stat.empty    = (count_reg == '0);
    assign stat.hit      = !go_left && !go_right;
    assign stat.more     = lo_cand < hi_cand;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_answer = out_ans_reg;
    assign out_status = out_st_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RANGES))
        else $error("entry count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (lo_reg < hi_reg) && ({1'b0, mid_reg} < count_reg))
        else $error("search probe outside loaded entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && req_reg == REQ_CLEAR) |=> (count_reg == '0 && rank_reg == '0))
        else $error("clear did not empty the table");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || out_ready))
        else $error("result pushed over an undelivered result");

endmodule

[sv/range_rank_select_table.sv]
// Top level of the range rank/select table: controller, datapath and channels.
//
//   Channel  Direction  Word contents
//   req      in         req_type, range_start, range_end, query_value
//   rsp      out        answer, status
//
// One request is in flight at a time. Clear and append go from acceptance
// through an execute state to the done state, which moves their result word
// into the output register once it is free. A lookup runs a start state and
// then one search step per binary-search probe, at most ceil(log2(entries + 1)) probes.
// Each probe is one read of the entry memory followed by a compare.
// Reset empties the table at once; entry contents are not cleared.
// A stalled result stays in the output register; the next request is taken
// while it waits, and its own result holds until the register frees.
module range_rank_select_table
    import rrst_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    rrst_req_if.sink req,
    rrst_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rrst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrst_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_req_type    (req.req_type),
        .in_range_start (req.range_start),
        .in_range_end   (req.range_end),
        .in_query_value (req.query_value),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_answer     (rsp.answer),
        .out_status     (rsp.status)
    );

endmodule
